/* sv/stmd_pkg.sv */
// Package for the trimmed-mean sensor deviation block.
// Holds window sizing, arithmetic widths and register indexes; no dependencies.
package stmd_pkg;

  // Samples per window and derived counter widths.
  localparam int WIN_LEN = 10;
  localparam int CNT_W   = $clog2(WIN_LEN);
  localparam int K_W     = $clog2(WIN_LEN + 2);
  localparam int MID     = WIN_LEN / 2;
  localparam int NCH     = 3;

  // Field widths.
  localparam int SMP_W = 8;
  localparam int LVL_W = 15;
  localparam int DEV_W = 8;
  localparam int SUM_W = 10;

  // Shared divider and multiplier widths.
  localparam int NUM_W = 50;
  localparam int DEN_W = 17;
  localparam int DCNT_W = 6;
  localparam int MUL_W = 27;
  localparam int QW    = 10;
  localparam int QB_W  = 4;

  // Arithmetic constants.
  localparam int PCT       = 100;
  localparam int SAT_LEVEL = 25500;
  localparam int DEV_SCALE = 1000;
  localparam int FILT_DIV  = 10;
  localparam int CLAMP     = 100;

  // Reciprocals for the divisions by three and by ten: x/3 = (x*683) >> 11 holds for
  // x below 2048, x/10 = (x*52429) >> 19 holds far beyond the filter's range.
  localparam int RECIP3     = 683;
  localparam int RECIP3_SH  = 11;
  localparam int RECIP10    = 52429;
  localparam int RECIP10_SH = 19;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_idx_e;

endpackage

/* sv/stmd_in_if.sv */
// Input channel of the deviation block: one word of three sensor samples.
// Depends on stmd_pkg for field widths.
interface stmd_in_if;
  logic                          valid;
  logic                          ready;
  logic [stmd_pkg::SMP_W-1:0]    left_sample;
  logic [stmd_pkg::SMP_W-1:0]    right_sample;
  logic [stmd_pkg::SMP_W-1:0]    middle_sample;
  logic                          kind;
  logic                          running;

  modport source(output valid, left_sample, right_sample, middle_sample, kind, running,
                 input ready);
  modport sink(input valid, left_sample, right_sample, middle_sample, kind, running,
               output ready);
endinterface

/* sv/stmd_out_if.sv */
// Output channel of the deviation block: levels and filtered steering deviation.
// Depends on stmd_pkg for field widths.
interface stmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [stmd_pkg::LVL_W-1:0]    left_level;
  logic [stmd_pkg::LVL_W-1:0]    right_level;
  logic [stmd_pkg::LVL_W-1:0]    middle_level;
  logic signed [stmd_pkg::DEV_W-1:0] steer_deviation;

  modport source(output valid, left_level, right_level, middle_level, steer_deviation,
                 input ready);
  modport sink(input valid, left_level, right_level, middle_level, steer_deviation,
               output ready);
endinterface

/* sv/stmd_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module stmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One access per cycle: a write when enabled, plus a registered read (old data on a write).
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* sv/stmd_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on stmd_pkg for operand widths.
module stmd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [stmd_pkg::NUM_W-1:0]    num_i,
  input  logic [stmd_pkg::DEN_W-1:0]    den_i,
  output logic                          done_o,
  output logic [stmd_pkg::NUM_W-1:0]    quot_o
);

  logic                          busy_q;
  logic [stmd_pkg::DCNT_W-1:0]   cnt_q;
  logic [stmd_pkg::NUM_W-1:0]    qr_q;
  logic [stmd_pkg::DEN_W-1:0]    rem_q;
  logic [stmd_pkg::DEN_W-1:0]    den_q;
  logic [stmd_pkg::DEN_W:0]      trial;
  logic                          ge;
  logic [stmd_pkg::DEN_W:0]      diff;
  logic                          last_step;

  // Shift in the next numerator bit and try a subtract.
  assign trial     = {rem_q, qr_q[stmd_pkg::NUM_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign diff      = trial - {1'b0, den_q};
  assign quot_o    = qr_q;
  assign last_step = busy_q && !start_i &&
                     (cnt_q == stmd_pkg::DCNT_W'(stmd_pkg::NUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        qr_q   <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? diff[stmd_pkg::DEN_W-1:0] : trial[stmd_pkg::DEN_W-1:0];
        qr_q  <= {qr_q[stmd_pkg::NUM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* sv/sensor_trimmed_mean_deviation.sv */
// Top level: windowed trimmed-mean normalizer with left/right steering deviation.
// Depends on stmd_pkg, stmd_in_if, stmd_out_if, stmd_ram and stmd_div.
//
//   channel   direction  handshake        content
//   samp_i    in         valid/ready      left/right/middle samples, kind, running
//   res_o     out        valid/ready      three levels and steer_deviation
//   cfg_*_i   in         write enable     deviation_bias (0), spike_limit (1)
//
// Words that do not end their window are taken back to back. At window end each
// channel is ranked over the sample RAM and its mean taken by a reciprocal multiply;
// ready stays low meanwhile. A measurement adds a divide for each channel that needs
// one, then the deviation divide, square-root search and filter, and waits longer
// while the last result word has not been taken. Reset clears min/max, the last levels,
// the filter and the bias and sets spike_limit to 60; the sample RAM is not cleared.
module sensor_trimmed_mean_deviation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  stmd_in_if.sink                           samp_i,
  stmd_out_if.source                        res_o,
  input  logic                              cfg_we_i,
  input  logic [stmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [7:0]                        cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RANK, ST_MEAN, ST_CHAN, ST_NORM, ST_SPIKE, ST_DM1, ST_DM2,
    ST_DDIV, ST_BM1, ST_BM2, ST_BCMP, ST_FILT, ST_FDIV, ST_DONE
  } state_e;

  localparam int RAM_W = 3 * stmd_pkg::SMP_W;
  localparam int PW    = 2 * stmd_pkg::MUL_W;

  state_e                             state_q;
  logic [stmd_pkg::CNT_W-1:0]         cnt_q;
  logic                               kind_q;
  logic                               rej_q;
  logic signed [7:0]                  bias_q;
  logic [7:0]                         limit_q;
  logic [1:0]                         ch_q;
  logic [stmd_pkg::CNT_W-1:0]         i_q;
  logic [stmd_pkg::K_W-1:0]           k_q;
  logic [stmd_pkg::CNT_W-1:0]         rank_q;
  logic [7:0]                         pivot_q;
  logic [stmd_pkg::SUM_W-1:0]         sum_q;
  logic [7:0]                         mean_q;
  logic [7:0]                         min_q [stmd_pkg::NCH];
  logic [7:0]                         max_q [stmd_pkg::NCH];
  logic [stmd_pkg::LVL_W-1:0]         last_q [stmd_pkg::NCH];
  logic [stmd_pkg::LVL_W-1:0]         lvl_q [stmd_pkg::NCH];
  logic [stmd_pkg::LVL_W-1:0]         cand_q;
  logic [stmd_pkg::DEN_W-1:0]         s_q;
  logic                               dneg_q;
  logic [PW-1:0]                      prod_q;
  logic [stmd_pkg::NUM_W-1:0]         lim_q;
  logic [stmd_pkg::QW-1:0]            q_q;
  logic [stmd_pkg::QB_W-1:0]          bit_q;
  logic                               fneg_q;
  logic signed [7:0]                  prev_q;
  logic                               div_start_q;
  logic [stmd_pkg::NUM_W-1:0]         div_num_q;
  logic [stmd_pkg::DEN_W-1:0]         div_den_q;
  logic                               ovalid_q;
  logic [stmd_pkg::LVL_W-1:0]         oleft_q, oright_q, omid_q;
  logic signed [7:0]                  odev_q;

  logic                               acc;
  logic                               ram_we;
  logic [stmd_pkg::CNT_W-1:0]         ram_addr;
  logic [stmd_pkg::CNT_W-1:0]         rd_addr;
  logic [RAM_W-1:0]                   ram_rdata;
  logic [7:0]                         cur;
  logic [stmd_pkg::K_W-1:0]           jx;
  logic                               hit;
  logic [stmd_pkg::CNT_W-1:0]         rank_n;
  logic                               in_mid;
  logic                               div_go;
  logic                               div_done;
  logic [stmd_pkg::NUM_W-1:0]         div_quot;
  logic [stmd_pkg::MUL_W-1:0]         mul_a, mul_b;
  logic [PW-1:0]                      prod;
  logic [stmd_pkg::QW-1:0]            qtry;
  logic signed [15:0]                 dsig;
  logic [stmd_pkg::LVL_W-1:0]         absd;
  logic [stmd_pkg::LVL_W-1:0]         spdiff;
  logic signed [11:0]                 raw_s;
  logic signed [15:0]                 fx;
  logic [15:0]                        fmag;
  logic signed [10:0]                 fs;
  logic signed [7:0]                  fclamp;
  logic                               ch_last;

  // Input handshake and sample RAM port.
  assign acc            = samp_i.valid & samp_i.ready;
  assign samp_i.ready   = (state_q == ST_IDLE);
  assign ram_we         = acc;
  assign ram_addr       = ram_we ? cnt_q : rd_addr;

  stmd_ram #(.WIDTH(RAM_W), .DEPTH(stmd_pkg::WIN_LEN)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({samp_i.middle_sample, samp_i.right_sample, samp_i.left_sample}),
    .rdata_o (ram_rdata)
  );

  // The divider starts for a normalization with mean above min and a nonzero span, and for the deviation.
  assign div_go = (state_q == ST_DM2) ||
                  ((state_q == ST_CHAN) && kind_q && (min_q[ch_q] < mean_q) &&
                   (max_q[ch_q] > min_q[ch_q]));

  stmd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Ranking: step 0 reads the pivot, later steps read every sample in turn.
  always_comb begin
    if (k_q == '0) begin
      rd_addr = i_q;
    end else if (k_q > stmd_pkg::K_W'(stmd_pkg::WIN_LEN)) begin
      rd_addr = '0;
    end else begin
      rd_addr = stmd_pkg::CNT_W'(k_q - 1'b1);
    end
  end

  assign cur    = ram_rdata[ch_q*8 +: 8];
  assign jx     = k_q - stmd_pkg::K_W'(2);
  assign hit    = (cur < pivot_q) ||
                  ((cur == pivot_q) && (jx < stmd_pkg::K_W'(i_q)));
  assign rank_n = rank_q + stmd_pkg::CNT_W'(hit);
  assign in_mid = (rank_n == stmd_pkg::CNT_W'(stmd_pkg::MID - 1)) ||
                  (rank_n == stmd_pkg::CNT_W'(stmd_pkg::MID)) ||
                  (rank_n == stmd_pkg::CNT_W'(stmd_pkg::MID + 1));
  assign ch_last = (ch_q == 2'(stmd_pkg::NCH - 1));

  // Deviation terms and spike distance.
  assign dsig   = $signed({1'b0, lvl_q[1]}) - $signed({1'b0, lvl_q[0]});
  assign absd   = dsig[15] ? stmd_pkg::LVL_W'(-dsig) : stmd_pkg::LVL_W'(dsig);
  assign spdiff = (last_q[ch_q] >= cand_q) ? last_q[ch_q] - cand_q : cand_q - last_q[ch_q];
  assign qtry   = q_q | (stmd_pkg::QW'(1) << bit_q);

  // Shared multiplier operand select; the product is combinational, some states register it.
  always_comb begin
    case (state_q)
      ST_MEAN: begin
        mul_a = stmd_pkg::MUL_W'(sum_q);
        mul_b = stmd_pkg::MUL_W'(stmd_pkg::RECIP3);
      end
      ST_DM1: begin
        mul_a = stmd_pkg::MUL_W'(stmd_pkg::DEV_SCALE);
        mul_b = stmd_pkg::MUL_W'(absd);
      end
      ST_DM2, ST_BM2: begin
        mul_a = prod_q[stmd_pkg::MUL_W-1:0];
        mul_b = prod_q[stmd_pkg::MUL_W-1:0];
      end
      ST_BM1: begin
        mul_a = stmd_pkg::MUL_W'(qtry);
        mul_b = stmd_pkg::MUL_W'(s_q);
      end
      ST_FILT: begin
        mul_a = stmd_pkg::MUL_W'(fmag);
        mul_b = stmd_pkg::MUL_W'(stmd_pkg::RECIP10);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Low-pass filter numerator and clamped result.
  assign raw_s  = (dneg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q})) +
                  $signed({{4{bias_q[7]}}, bias_q});
  assign fx     = ($signed({{8{prev_q[7]}}, prev_q}) <<< 1) +
                  ($signed({{4{raw_s[11]}}, raw_s}) <<< 3);
  assign fmag   = fx[15] ? 16'(-fx) : 16'(fx);
  assign fs     = fneg_q ? -$signed({1'b0, prod_q[stmd_pkg::RECIP10_SH +: stmd_pkg::QW]})
                         : $signed({1'b0, prod_q[stmd_pkg::RECIP10_SH +: stmd_pkg::QW]});
  always_comb begin
    if (fs > 11'sd100) begin
      fclamp = 8'sd100;
    end else if (fs < -11'sd100) begin
      fclamp = -8'sd100;
    end else begin
      fclamp = fs[7:0];
    end
  end

  // Output channel.
  assign res_o.valid           = ovalid_q;
  assign res_o.left_level      = oleft_q;
  assign res_o.right_level     = oright_q;
  assign res_o.middle_level    = omid_q;
  assign res_o.steer_deviation = odev_q;

  // Sequencer with all state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rej_q       <= 1'b0;
      bias_q      <= '0;
      limit_q     <= 8'd60;
      prev_q      <= '0;
      ovalid_q    <= 1'b0;
      div_start_q <= 1'b0;
      for (int c = 0; c < stmd_pkg::NCH; c++) begin
        min_q[c]  <= 8'hFF;
        max_q[c]  <= '0;
        last_q[c] <= '0;
      end
    end else begin
      div_start_q <= div_go;

      // Register writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          stmd_pkg::CFG_BIAS:  bias_q  <= cfg_data_i;
          stmd_pkg::CFG_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end

      // A taken word frees the output register; the load state handles it itself.
      if (ovalid_q && res_o.ready && (state_q != ST_DONE)) begin
        ovalid_q <= 1'b0;
      end

      case (state_q)
        // Take one sample word; the last one of a window starts the work.
        ST_IDLE: begin
          if (acc) begin
            if (cnt_q == stmd_pkg::CNT_W'(stmd_pkg::WIN_LEN - 1)) begin
              cnt_q  <= '0;
              kind_q <= samp_i.kind;
              if (samp_i.kind && samp_i.running) begin
                rej_q <= 1'b1;
              end
              ch_q    <= '0;
              i_q     <= '0;
              k_q     <= '0;
              rank_q  <= '0;
              sum_q   <= '0;
              state_q <= ST_RANK;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end

        // Rank each sample; the three middle ranks feed the sum.
        ST_RANK: begin
          if (k_q == stmd_pkg::K_W'(1)) begin
            pivot_q <= cur;
          end
          if (k_q == stmd_pkg::K_W'(stmd_pkg::WIN_LEN + 1)) begin
            if (in_mid) begin
              sum_q <= sum_q + stmd_pkg::SUM_W'(pivot_q);
            end
            k_q    <= '0;
            rank_q <= '0;
            if (i_q == stmd_pkg::CNT_W'(stmd_pkg::WIN_LEN - 1)) begin
              state_q <= ST_MEAN;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            if (k_q >= stmd_pkg::K_W'(2)) begin
              rank_q <= rank_n;
            end
            k_q <= k_q + 1'b1;
          end
        end

        // Mean of the middle three by reciprocal multiply.
        ST_MEAN: begin
          mean_q  <= prod[stmd_pkg::RECIP3_SH +: stmd_pkg::SMP_W];
          state_q <= ST_CHAN;
        end

        // Calibrate min/max, or pick the level path.
        ST_CHAN: begin
          if (!kind_q) begin
            if (mean_q > max_q[ch_q]) max_q[ch_q] <= mean_q;
            if (mean_q < min_q[ch_q]) min_q[ch_q] <= mean_q;
            if (ch_last) begin
              state_q <= ST_IDLE;
            end else begin
              ch_q    <= ch_q + 1'b1;
              i_q     <= '0;
              sum_q   <= '0;
              state_q <= ST_RANK;
            end
          end else if (min_q[ch_q] >= mean_q) begin
            cand_q  <= stmd_pkg::LVL_W'(1);
            state_q <= ST_SPIKE;
          end else if (max_q[ch_q] <= min_q[ch_q]) begin
            cand_q  <= stmd_pkg::LVL_W'(stmd_pkg::SAT_LEVEL);
            state_q <= ST_SPIKE;
          end else begin
            div_num_q   <= stmd_pkg::NUM_W'(stmd_pkg::LVL_W'(stmd_pkg::PCT) *
                                             stmd_pkg::LVL_W'(mean_q - min_q[ch_q]));
            div_den_q   <= stmd_pkg::DEN_W'(max_q[ch_q] - min_q[ch_q]);
            state_q     <= ST_NORM;
          end
        end

        ST_NORM: begin
          if (div_done) begin
            cand_q  <= div_quot[stmd_pkg::LVL_W-1:0];
            state_q <= ST_SPIKE;
          end
        end

        // Once a running measurement has armed rejection, a jump of at least the limit keeps the last level.
        ST_SPIKE: begin
          if (rej_q && (spdiff >= stmd_pkg::LVL_W'(limit_q))) begin
            lvl_q[ch_q] <= last_q[ch_q];
          end else begin
            lvl_q[ch_q]  <= cand_q;
            last_q[ch_q] <= cand_q;
          end
          if (ch_last) begin
            state_q <= ST_DM1;
          end else begin
            ch_q    <= ch_q + 1'b1;
            i_q     <= '0;
            sum_q   <= '0;
            state_q <= ST_RANK;
          end
        end

        // n = 1000*|R-L|, then n*n, then divide by S.
        ST_DM1: begin
          s_q     <= stmd_pkg::DEN_W'(lvl_q[0]) + stmd_pkg::DEN_W'(lvl_q[1]) +
                     stmd_pkg::DEN_W'(lvl_q[2]) + stmd_pkg::DEN_W'(1);
          dneg_q  <= dsig[15];
          prod_q  <= prod;
          state_q <= ST_DM2;
        end

        ST_DM2: begin
          div_num_q   <= prod[stmd_pkg::NUM_W-1:0];
          div_den_q   <= s_q;
          state_q     <= ST_DDIV;
        end

        ST_DDIV: begin
          if (div_done) begin
            lim_q   <= div_quot;
            q_q     <= '0;
            bit_q   <= stmd_pkg::QB_W'(stmd_pkg::QW - 1);
            state_q <= ST_BM1;
          end
        end

        // Bit search for the largest q with (q*S)^2 <= n*n/S.
        ST_BM1: begin
          prod_q  <= prod;
          state_q <= ST_BM2;
        end

        ST_BM2: begin
          prod_q  <= prod;
          state_q <= ST_BCMP;
        end

        ST_BCMP: begin
          if (prod_q <= PW'(lim_q)) begin
            q_q <= qtry;
          end
          if (bit_q == '0) begin
            state_q <= ST_FILT;
          end else begin
            bit_q   <= bit_q - 1'b1;
            state_q <= ST_BM1;
          end
        end

        // Filter: (2*last + 8*raw) / 10, truncated toward zero, by reciprocal multiply, clamped to +-100.
        ST_FILT: begin
          fneg_q  <= fx[15];
          prod_q  <= prod;
          state_q <= ST_FDIV;
        end

        ST_FDIV: begin
          prev_q  <= fclamp;
          state_q <= ST_DONE;
        end

        // Load the result word once the output register is free.
        ST_DONE: begin
          if (!ovalid_q || res_o.ready) begin
            ovalid_q <= 1'b1;
            oleft_q  <= lvl_q[0];
            oright_q <= lvl_q[1];
            omid_q   <= lvl_q[2];
            odev_q   <= prev_q;
            state_q  <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
